FILE: sv/hist_pkg.sv
// Shared types, constants and helper functions for the 2D histogram block.
// Used by every module of the block; depends on nothing else.
package hist_pkg;

	localparam int MAX_BINS_X   = 64;
	localparam int MAX_BINS_Y   = 64;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 24;
	localparam int ROW_W        = 6;
	localparam int COL_W        = 6;
	localparam int ADDR_W       = ROW_W + COL_W;
	localparam int STORE_DEPTH  = MAX_BINS_X * MAX_BINS_Y;
	localparam int FRAC_W       = 16;
	localparam int DVD_W        = COUNT_WIDTH + FRAC_W;
	localparam int DVS_W        = COUNT_WIDTH;
	localparam int STEP_W       = $clog2(DVD_W);
	localparam int BINREG_W     = 7;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = SAMPLE_WIDTH;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] Q16_ONE   = COUNT_WIDTH'(65536);

	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_PEAK = 2'd1;
	localparam logic [1:0] MODE_CDF  = 2'd2;
	localparam logic [1:0] DIM_TWO   = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_FINAL = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMENSIONS  = 3'd0,
		CFG_MIN_X       = 3'd1,
		CFG_MAX_X       = 3'd2,
		CFG_BINS_X      = 3'd3,
		CFG_MIN_Y       = 3'd4,
		CFG_MAX_Y       = 3'd5,
		CFG_BINS_Y      = 3'd6,
		CFG_OUTPUT_MODE = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		op_t                            operation;
		logic signed [SAMPLE_WIDTH-1:0] sample_x;
		logic signed [SAMPLE_WIDTH-1:0] sample_y;
		logic [ROW_W-1:0]               read_row;
		logic [COL_W-1:0]               read_col;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] selected_value;
		logic [COUNT_WIDTH-1:0] total_samples;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CLR_STEP,
		CMD_MUL_X,
		CMD_MUL_Y,
		CMD_DIV_START,
		CMD_BIN,
		CMD_ADD_RD,
		CMD_ADD_WR,
		CMD_FIN_RD,
		CMD_FIN_WR,
		CMD_RD_MEM,
		CMD_FRAC_START,
		CMD_OUT
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sweep_last;
		logic two_dim;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL_X,
		ST_DIV_X,
		ST_WAIT_X,
		ST_MUL_Y,
		ST_DIV_Y,
		ST_WAIT_Y,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_RD_MEM,
		ST_FRAC,
		ST_WAIT_F,
		ST_OUT
	} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [BINREG_W-1:0] eff_bins(input logic [BINREG_W-1:0] r,
		input logic [BINREG_W-1:0] maxb);
		logic [BINREG_W-1:0] e;
		e = r;
		if (r == '0) begin
			e = BINREG_W'(1);
		end else if (r > maxb) begin
			e = maxb;
		end
		return e;
	endfunction

endpackage

FILE: sv/hist_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hist_pkg for widths.
module hist_div import hist_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0]  dq_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DVS_W:0]    rem_sh;
	logic              ge;

	assign rem_sh = {rem_q[DVS_W-1:0], dq_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

FILE: sv/hist_dp.sv
// Datapath: configuration registers, count and cumulative stores, binning,
// finalize sweep arithmetic and the output register. Uses hist_pkg and hist_div.
module hist_dp import hist_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  in_item_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_status_t            status,
	output out_item_t             out_data
);

	logic [1:0]                     dim_q, mode_q;
	logic signed [SAMPLE_WIDTH-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [BINREG_W-1:0]            bins_x_q, bins_y_q;

	in_item_t               item_q;
	logic                   axis_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [ADDR_W-1:0]      cnt_q;
	logic [COUNT_WIDTH-1:0] peak_q, total_q, run_q, mul_q;
	logic [COUNT_WIDTH-1:0] cnt_rd_q, cum_rd_q, col_rd_q;
	logic [COUNT_WIDTH-1:0] num_q;
	out_item_t              out_q;

	logic [COUNT_WIDTH-1:0] cnt_mem [STORE_DEPTH];
	logic [COUNT_WIDTH-1:0] cum_mem [STORE_DEPTH];
	logic [COUNT_WIDTH-1:0] col_mem [MAX_BINS_Y];

	logic                           sel_y;
	logic signed [SAMPLE_WIDTH-1:0] s, lo, hi;
	logic [BINREG_W-1:0]            eb;
	logic signed [SAMPLE_WIDTH:0]   diff, span;
	logic                           bin_zero;
	logic [ROW_W-1:0]               idx;
	logic                           div_start, div_busy;
	logic [DVD_W-1:0]               dvd, quo;
	logic [DVS_W-1:0]               dvs;
	logic [COUNT_WIDTH-1:0]         den, num, run_new, p, peak_new, sel_val;
	logic [ADDR_W-1:0]              rd_addr, item_addr, bin_addr;
	logic                           first_col, first_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= 2'd1;
			min_x_q  <= '0;
			max_x_q  <= SAMPLE_WIDTH'(255);
			bins_x_q <= BINREG_W'(16);
			min_y_q  <= '0;
			max_y_q  <= SAMPLE_WIDTH'(255);
			bins_y_q <= BINREG_W'(1);
			mode_q   <= MODE_RAW;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIMENSIONS:  dim_q    <= cfg_data[1:0];
				CFG_MIN_X:       min_x_q  <= cfg_data;
				CFG_MAX_X:       max_x_q  <= cfg_data;
				CFG_BINS_X:      bins_x_q <= cfg_data[BINREG_W-1:0];
				CFG_MIN_Y:       min_y_q  <= cfg_data;
				CFG_MAX_Y:       max_y_q  <= cfg_data;
				CFG_BINS_Y:      bins_y_q <= cfg_data[BINREG_W-1:0];
				CFG_OUTPUT_MODE: mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Axis selection: the multiply step names the axis, later steps follow axis_q.
	assign sel_y = (cmd == CMD_MUL_Y) || ((cmd != CMD_MUL_X) && axis_q);
	assign s     = sel_y ? item_q.sample_y : item_q.sample_x;
	assign lo    = sel_y ? min_y_q : min_x_q;
	assign hi    = sel_y ? max_y_q : max_x_q;
	assign eb    = sel_y ? eff_bins(bins_y_q, BINREG_W'(MAX_BINS_Y))
		: eff_bins(bins_x_q, BINREG_W'(MAX_BINS_X));
	assign diff     = {s[SAMPLE_WIDTH-1], s} - {lo[SAMPLE_WIDTH-1], lo};
	assign span     = {hi[SAMPLE_WIDTH-1], hi} - {lo[SAMPLE_WIDTH-1], lo};
	assign bin_zero = (hi <= lo) || (s < lo);
	assign idx = bin_zero ? '0
		: ((|quo[DVD_W-1:BINREG_W]) || (quo[BINREG_W-1:0] >= eb))
			? ROW_W'(eb - BINREG_W'(1)) : quo[ROW_W-1:0];

	assign den = (mode_q == MODE_PEAK) ? peak_q : total_q;
	assign num = (mode_q == MODE_PEAK) ? cnt_rd_q : cum_rd_q;

	assign div_start = (cmd == CMD_DIV_START) || (cmd == CMD_FRAC_START);
	assign dvd = (cmd == CMD_FRAC_START) ? {num, FRAC_W'(0)} : DVD_W'(mul_q);
	assign dvs = (cmd == CMD_FRAC_START) ? den : DVS_W'(span[SAMPLE_WIDTH-1:0]);

	hist_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			item_q <= in_data;
		end
		if (cmd == CMD_MUL_X || cmd == CMD_MUL_Y) begin
			axis_q <= (cmd == CMD_MUL_Y);
			mul_q  <= COUNT_WIDTH'(COUNT_WIDTH'(diff[SAMPLE_WIDTH-1:0])
				* COUNT_WIDTH'(eb));
		end
		if (cmd == CMD_MUL_X) begin
			col_q <= '0;
		end
		if (cmd == CMD_BIN) begin
			if (axis_q) begin
				col_q <= idx;
			end else begin
				row_q <= idx;
			end
		end
		if (cmd == CMD_FRAC_START) begin
			num_q <= num;
		end
	end

	// Finalize arithmetic. The column accumulators are kept saturated; since they
	// only grow, this gives the same clipped prefix sums as unbounded ones.
	assign first_col = (cnt_q[COL_W-1:0] == '0);
	assign first_row = (cnt_q[ADDR_W-1:COL_W] == '0);
	assign run_new   = sat_add(first_col ? '0 : run_q, cnt_rd_q);
	assign p         = sat_add(first_row ? '0 : col_rd_q, run_new);
	assign peak_new  = (cnt_q == '0 || cnt_rd_q > peak_q) ? cnt_rd_q : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			peak_q  <= '0;
			total_q <= '0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					cnt_q <= '0;
					if (in_data.operation == OP_CLEAR) begin
						peak_q  <= '0;
						total_q <= '0;
					end
				end
				CMD_CLR_STEP: cnt_q <= cnt_q + ADDR_W'(1);
				CMD_ADD_WR:   total_q <= sat_add(total_q, COUNT_WIDTH'(1));
				CMD_FIN_WR: begin
					cnt_q  <= cnt_q + ADDR_W'(1);
					peak_q <= peak_new;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_FIN_WR) begin
			run_q <= run_new;
		end
	end

	assign item_addr = {item_q.read_row, item_q.read_col};
	assign bin_addr  = {row_q, col_q};
	assign rd_addr   = (cmd == CMD_ADD_RD) ? bin_addr
		: (cmd == CMD_FIN_RD) ? cnt_q : item_addr;

	always_ff @(posedge clk) begin
		if (cmd == CMD_CLR_STEP) begin
			cnt_mem[cnt_q] <= '0;
		end else if (cmd == CMD_ADD_WR) begin
			cnt_mem[bin_addr] <= sat_add(cnt_rd_q, COUNT_WIDTH'(1));
		end
		if (cmd == CMD_ADD_RD || cmd == CMD_FIN_RD || cmd == CMD_RD_MEM) begin
			cnt_rd_q <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_FIN_WR) begin
			cum_mem[cnt_q] <= p;
		end
		if (cmd == CMD_RD_MEM) begin
			cum_rd_q <= cum_mem[item_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_FIN_WR) begin
			col_mem[cnt_q[COL_W-1:0]] <= p;
		end
		if (cmd == CMD_FIN_RD) begin
			col_rd_q <= col_mem[cnt_q[COL_W-1:0]];
		end
	end

	// A fraction of one or more reads as exactly one; below that the
	// divider's low bits are the Q0.16 quotient.
	always_comb begin
		sel_val = cnt_rd_q;
		if (mode_q == MODE_PEAK || mode_q == MODE_CDF) begin
			if (den == '0) begin
				sel_val = '0;
			end else if (num_q >= den) begin
				sel_val = Q16_ONE;
			end else begin
				sel_val = COUNT_WIDTH'(quo[FRAC_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_OUT) begin
			out_q.selected_value <= sel_val;
			out_q.total_samples  <= total_q;
		end
	end

	assign out_data          = out_q;
	assign status.div_busy   = div_busy;
	assign status.sweep_last = (cnt_q == '1);
	assign status.two_dim    = (dim_q == DIM_TWO);

endmodule

FILE: sv/hist_ctrl.sv
// Controller state machine: sequences clear, add, finalize and read beats
// and owns the handshake flags. Uses hist_pkg; drives hist_dp by commands.
module hist_ctrl import hist_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  op_t        in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd = CMD_CLR_STEP;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = CMD_LOAD;
					case (in_op)
						OP_CLEAR: state_d = ST_CLR;
						OP_ADD:   state_d = ST_MUL_X;
						OP_FINAL: state_d = ST_FIN_RD;
						OP_READ:  state_d = ST_RD_MEM;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_X: begin
				cmd     = CMD_MUL_X;
				state_d = ST_DIV_X;
			end
			ST_DIV_X: begin
				cmd     = CMD_DIV_START;
				state_d = ST_WAIT_X;
			end
			ST_WAIT_X: begin
				if (!status.div_busy) begin
					cmd     = CMD_BIN;
					state_d = status.two_dim ? ST_MUL_Y : ST_ADD_RD;
				end
			end
			ST_MUL_Y: begin
				cmd     = CMD_MUL_Y;
				state_d = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				cmd     = CMD_DIV_START;
				state_d = ST_WAIT_Y;
			end
			ST_WAIT_Y: begin
				if (!status.div_busy) begin
					cmd     = CMD_BIN;
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				cmd     = CMD_ADD_RD;
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd     = CMD_ADD_WR;
				state_d = ST_IDLE;
			end
			ST_FIN_RD: begin
				cmd     = CMD_FIN_RD;
				state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				cmd     = CMD_FIN_WR;
				state_d = status.sweep_last ? ST_IDLE : ST_FIN_RD;
			end
			ST_RD_MEM: begin
				cmd     = CMD_RD_MEM;
				state_d = ST_FRAC;
			end
			ST_FRAC: begin
				cmd     = CMD_FRAC_START;
				state_d = ST_WAIT_F;
			end
			ST_WAIT_F: begin
				if (!status.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd     = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !status.div_busy)
		else $error("input taken while the divider is still busy");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_DIV_START || cmd == CMD_FRAC_START) |-> !status.div_busy)
		else $error("divider restarted mid-operation");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT) |=> out_valid)
		else $error("result loaded but not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_OUT) |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

endmodule

FILE: sv/histogram_2d_with_cdf_top.sv
// Top level of the 1D/2D histogram with peak and CDF readout.
// Depends on hist_pkg, hist_ctrl and hist_dp.
//
//  channel  | signals                      | beat
//  ---------+------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data  | one operation (in_item_t)
//  output   | out_valid, out_ready, out_data | one read result (out_item_t)
//  config   | cfg_we, cfg_index, cfg_data  | one register write, no wait
//
// After reset the count store is swept to zero with in_ready low; a clear beat takes
// the same sweep. An add beat is dominated by the serial divider, run once per axis.
// Finalize walks the 4096-entry store, reading and then writing each entry.
// A read's result waits on the divider; a waiting result does not stop new beats,
// but the next read then holds in its output state, in_ready low, until it is taken.
module histogram_2d_with_cdf_top import hist_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	hist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.operation),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	hist_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the 1D/2D histogram with peak and CDF readout.
// Depends on hist_pkg and histogram_2d_with_cdf_top; a predictor or directed values check every read beat.
`timescale 1ns / 1ps

module testbench;
	import hist_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	histogram_2d_with_cdf_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the registers and stores.
	logic [1:0]                     hm_dims;
	logic signed [SAMPLE_WIDTH-1:0] hm_min_x, hm_max_x, hm_min_y, hm_max_y;
	logic [BINREG_W-1:0]            hm_bins_x, hm_bins_y;
	logic [1:0]                     hm_mode;
	longint                         hm_counts [STORE_DEPTH];
	longint                         hm_cumul [STORE_DEPTH];
	longint                         hm_peak, hm_total;

	out_item_t pending_reads [$];
	int        errors = 0;
	bit        hold_request = 0;
	int        idle_cycles = 0;

	typedef struct {
		op_t            op;
		int             sx;
		int             sy;
		int             row;
		int             col;
		bit             typed;
		int             want_val;
		int             want_total;
	} dir_row_t;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic longint bins_in_use(logic [BINREG_W-1:0] r, int maxb);
		if (r == 0) return 1;
		if (r > maxb) return longint'(maxb);
		return longint'(r);
	endfunction

	function automatic longint axis_bin(logic signed [SAMPLE_WIDTH-1:0] s,
		logic signed [SAMPLE_WIDTH-1:0] lo, logic signed [SAMPLE_WIDTH-1:0] hi, longint nb);
		longint idx;
		if (hi <= lo || s < lo) return 0;
		idx = ((longint'(s) - longint'(lo)) * nb) / (longint'(hi) - longint'(lo));
		return (idx >= nb) ? nb - 1 : idx;
	endfunction

	function automatic longint q16_ratio(longint num, longint den);
		longint q;
		if (den == 0) return 0;
		q = (num * 65536) / den;
		return (q > 65536) ? 65536 : q;
	endfunction

	function automatic void build_prefix_sums();
		longint col_acc [MAX_BINS_Y];
		longint run, v;
		hm_peak = 0;
		foreach (col_acc[c]) col_acc[c] = 0;
		for (int r = 0; r < MAX_BINS_X; r++) begin
			run = 0;
			for (int c = 0; c < MAX_BINS_Y; c++) begin
				v = hm_counts[r * MAX_BINS_Y + c];
				if (v > hm_peak) hm_peak = v;
				run += v;
				col_acc[c] += run;
				hm_cumul[r * MAX_BINS_Y + c] = (col_acc[c] > COUNT_MAX) ? COUNT_MAX : col_acc[c];
			end
		end
	endfunction

	// Updates the predictor for one accepted beat and returns 1 with the read result.
	function automatic bit predict_beat(in_item_t it, output out_item_t res);
		longint row, col, k, val;
		res = '0;
		case (it.operation)
			OP_CLEAR: begin
				foreach (hm_counts[i]) hm_counts[i] = 0;
				hm_peak = 0;
				hm_total = 0;
			end
			OP_ADD: begin
				row = axis_bin(it.sample_x, hm_min_x, hm_max_x, bins_in_use(hm_bins_x, MAX_BINS_X));
				col = 0;
				if (hm_dims == DIM_TWO)
					col = axis_bin(it.sample_y, hm_min_y, hm_max_y,
						bins_in_use(hm_bins_y, MAX_BINS_Y));
				k = row * MAX_BINS_Y + col;
				if (hm_counts[k] < COUNT_MAX) hm_counts[k]++;
				if (hm_total < COUNT_MAX) hm_total++;
			end
			OP_FINAL: build_prefix_sums();
			default: begin
				k = longint'(it.read_row) * MAX_BINS_Y + longint'(it.read_col);
				if (hm_mode == MODE_PEAK) val = q16_ratio(hm_counts[k], hm_peak);
				else if (hm_mode == MODE_CDF) val = q16_ratio(hm_cumul[k], hm_total);
				else val = hm_counts[k];
				res.selected_value = val[COUNT_WIDTH-1:0];
				res.total_samples  = hm_total[COUNT_WIDTH-1:0];
				return 1;
			end
		endcase
		return 0;
	endfunction

	// Offers one beat after a random gap and waits for it to be taken.
	task automatic offer_beat(in_item_t it, bit typed, out_item_t typed_res);
		int gap;
		out_item_t res;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		if (predict_beat(it, res))
			pending_reads = {pending_reads, (typed ? typed_res : res)};
	endtask

	task automatic reg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		case (idx)
			CFG_DIMENSIONS:  hm_dims   = v[1:0];
			CFG_MIN_X:       hm_min_x  = v;
			CFG_MAX_X:       hm_max_x  = v;
			CFG_BINS_X:      hm_bins_x = v[BINREG_W-1:0];
			CFG_MIN_Y:       hm_min_y  = v;
			CFG_MAX_Y:       hm_max_y  = v;
			CFG_BINS_Y:      hm_bins_y = v[BINREG_W-1:0];
			default:         hm_mode   = v[1:0];
		endcase
	endtask

	// Ends a stretch of traffic: a closing read, then wait for every result.
	task automatic drain_block();
		in_item_t it;
		it = '0;
		it.operation = OP_READ;
		offer_beat(it, 1'b0, '0);
		in_valid <= 1'b0;
		while (pending_reads.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(int lo, int hi);
		int a, b;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		if ($urandom_range(0, 1)) return SAMPLE_WIDTH'($urandom);
		return SAMPLE_WIDTH'(a - 4 + int'($urandom_range(0, b - a + 8)));
	endfunction

	task automatic run_phase(logic [1:0] dims, int mnx, int mxx, int bx, int mny, int mxy,
		int by, logic [1:0] mode, int n, bit with_hold);
		in_item_t it;
		int r;
		int nbx, nby;
		nbx = int'(bins_in_use(BINREG_W'(bx), MAX_BINS_X));
		nby = int'(bins_in_use(BINREG_W'(by), MAX_BINS_Y));
		reg_write(CFG_DIMENSIONS, CFG_DATA_W'(dims));
		reg_write(CFG_MIN_X, CFG_DATA_W'(mnx));
		reg_write(CFG_MAX_X, CFG_DATA_W'(mxx));
		reg_write(CFG_BINS_X, CFG_DATA_W'(bx));
		reg_write(CFG_MIN_Y, CFG_DATA_W'(mny));
		reg_write(CFG_MAX_Y, CFG_DATA_W'(mxy));
		reg_write(CFG_BINS_Y, CFG_DATA_W'(by));
		reg_write(CFG_OUTPUT_MODE, CFG_DATA_W'(mode));
		cfg_we <= 1'b0;
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 2) hold_request = 1;
			it = '0;
			r = $urandom_range(0, 199);
			it.operation = (r < 3) ? OP_CLEAR : (r < 7) ? OP_FINAL : (r < 130) ? OP_ADD : OP_READ;
			it.sample_x = pick_sample(mnx, mxx);
			it.sample_y = pick_sample(mny, mxy);
			if ($urandom_range(0, 9) < 7) begin
				it.read_row = ROW_W'($urandom_range(0, nbx - 1));
				it.read_col = (dims == DIM_TWO) ? COL_W'($urandom_range(0, nby - 1)) : '0;
			end else begin
				it.read_row = ROW_W'($urandom);
				it.read_col = COL_W'($urandom);
			end
			offer_beat(it, 1'b0, '0);
		end
		drain_block();
	endtask

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int stall;
		out_item_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_reads.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat %h", $realtime, out_data);
			end else begin
				want = pending_reads.pop_front();
				if (out_data.selected_value !== want.selected_value) begin
					errors++;
					$display("%0t: selected_value expected %0d actual %0d", $realtime,
						want.selected_value, out_data.selected_value);
				end
				if (out_data.total_samples !== want.total_samples) begin
					errors++;
					$display("%0t: total_samples expected %0d actual %0d", $realtime,
						want.total_samples, out_data.total_samples);
				end
			end
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t  plan [$];
		in_item_t  it;
		out_item_t tres;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		hm_dims = 2'd1; hm_min_x = '0; hm_max_x = SAMPLE_WIDTH'(255);
		hm_bins_x = BINREG_W'(16);
		hm_min_y = '0; hm_max_y = SAMPLE_WIDTH'(255); hm_bins_y = BINREG_W'(1);
		hm_mode = MODE_RAW;
		foreach (hm_counts[i]) begin
			hm_counts[i] = 0;
			hm_cumul[i] = 0;
		end
		hm_peak = 0;
		hm_total = 0;

		// Reset settings: one axis, 0..255, sixteen bins, raw counts.
		plan = '{
			'{OP_READ,  0,      0,  0,  0,  1, 0, 0},
			'{OP_ADD,   -32768, 0,  0,  0,  0, 0, 0},
			'{OP_ADD,   32767,  0,  0,  0,  0, 0, 0},
			'{OP_ADD,   255,    0,  0,  0,  0, 0, 0},
			'{OP_ADD,   0,      0,  0,  0,  0, 0, 0},
			'{OP_ADD,   128,    -1, 0,  0,  0, 0, 0},
			'{OP_READ,  0,      0,  0,  0,  1, 2, 5},
			'{OP_READ,  0,      0,  15, 0,  1, 2, 5},
			'{OP_READ,  0,      0,  8,  0,  1, 1, 5},
			'{OP_READ,  0,      0,  63, 63, 1, 0, 5},
			'{OP_FINAL, 0,      0,  0,  0,  0, 0, 0},
			'{OP_READ,  0,      0,  8,  0,  0, 0, 0},
			'{OP_CLEAR, 0,      0,  0,  0,  0, 0, 0},
			'{OP_READ,  0,      0,  0,  0,  1, 0, 0},
			'{OP_ADD,   16,     0,  0,  0,  0, 0, 0},
			'{OP_FINAL, 0,      0,  0,  0,  0, 0, 0},
			'{OP_READ,  0,      0,  1,  0,  0, 0, 0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			it = '0;
			it.operation = plan[i].op;
			it.sample_x  = SAMPLE_WIDTH'(plan[i].sx);
			it.sample_y  = SAMPLE_WIDTH'(plan[i].sy);
			it.read_row  = ROW_W'(plan[i].row);
			it.read_col  = COL_W'(plan[i].col);
			tres.selected_value = COUNT_WIDTH'(plan[i].want_val);
			tres.total_samples  = COUNT_WIDTH'(plan[i].want_total);
			offer_beat(it, plan[i].typed, tres);
		end
		drain_block();

		// A finalize has been done, so the cumulative mode is safe from here on.
		run_phase(2'd2, -100, 100, 8, -50, 50, 8, MODE_PEAK, 150, 0);
		run_phase(2'd2, -32768, 32767, 64, -32768, 32767, 64, MODE_CDF, 150, 1);
		run_phase(2'd1, 10, 10, 0, 0, 0, 0, 2'd3, 100, 0);
		run_phase(2'd3, -1000, 1000, 127, 0, 0, 0, MODE_RAW, 100, 0);
		run_phase(2'd2, 0, 255, 1, 100, -100, 127, MODE_CDF, 150, 0);
		run_phase(2'd0, -20, 20, 5, -5, 5, 3, MODE_PEAK, 100, 0);
		run_phase(2'd2, -8, 8, 64, -8, 8, 64, MODE_RAW, 150, 1);
		run_phase(2'd2, 32767, -32768, 3, -300, 300, 33, MODE_CDF, 100, 0);

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
